// ===== hdl/fixed_point_mul_div_mod_assert.svh =====
// Assertion macros for the fixed-point multiply/divide/modulo unit
`ifndef FIXED_POINT_MUL_DIV_MOD_ASSERT_SVH
`define FIXED_POINT_MUL_DIV_MOD_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FPMD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FPMD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FPMD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define FPMD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/fpmd_pkg.sv =====
// Shared types and constants for the fixed-point multiply/divide/modulo unit
`timescale 1ns / 1ps
package fpmd_pkg;
    localparam int DATA_W = 32;
    localparam int GUARD_SHIFT = 14;
    localparam int MODE_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_MUL = 2'd0,
        MODE_DIV = 2'd1,
        MODE_MOD = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    // Operation summary decided up front, carried alongside the divider
    typedef struct packed {
        mode_t       mode;
        logic        sat;
        logic        sat_neg;
        logic        mask_mod;
        logic [31:0] mask_val;
        logic        neg_q;
        logic        neg_r;
        logic [31:0] b_val;
    } ctl_t;
endpackage

// ===== hdl/fpmd_mul.sv =====
// Registered signed multiplier with arithmetic right shift by the fraction width, then a delay line
`timescale 1ns / 1ps
module fpmd_mul #(
    parameter int FRAC_BITS = 16,
    parameter int LAT = 34
) (
    input  logic               aclk,
    input  logic               ce,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic        [31:0] prod
);
    logic signed [63:0] p_reg;
    logic signed [63:0] sh;
    logic [31:0] dly_reg [LAT-1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_reg <= a * b;
            dly_reg[0] <= sh[31:0];
            for (int i = 1; i < LAT - 1; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end
    assign sh = p_reg >>> FRAC_BITS;
    assign prod = dly_reg[LAT-2];
endmodule

// ===== hdl/fpmd_div.sv =====
// Restoring divider, one quotient bit per pipeline stage over an unsigned NUM_W/32 divide
`timescale 1ns / 1ps
module fpmd_div #(
    parameter int NUM_W = 48
) (
    input  logic              aclk,
    input  logic              ce,
    input  logic [NUM_W-1:0]  num,
    input  logic [31:0]       den,
    output logic [NUM_W-1:0]  quo,
    output logic [31:0]       rem
);
    logic [NUM_W-1:0] q_reg [NUM_W];
    logic [31:0]      r_reg [NUM_W];
    logic [31:0]      d_reg [NUM_W-1];

    // Shift in the next numerator bit and subtract the divisor when it fits;
    // the partial remainder stays below the divisor, so 32 bits hold it
    function automatic logic [NUM_W+31:0] div_step(logic [31:0] r_in,
                                                    logic [NUM_W-1:0] q_in,
                                                    logic [31:0] d_in);
        logic [32:0] trial;
        logic [32:0] diff;
        trial = {r_in, q_in[NUM_W-1]};
        diff = trial - {1'b0, d_in};
        if (!diff[32]) begin
            return {diff[31:0], q_in[NUM_W-2:0], 1'b1};
        end
        return {trial[31:0], q_in[NUM_W-2:0], 1'b0};
    endfunction

    always_ff @(posedge aclk) begin
        if (ce) begin
            {r_reg[0], q_reg[0]} <= div_step(32'd0, num, den);
            d_reg[0] <= den;
            for (int i = 1; i < NUM_W; i++) begin
                {r_reg[i], q_reg[i]} <= div_step(r_reg[i-1], q_reg[i-1], d_reg[i-1]);
                if (i < NUM_W - 1) begin
                    d_reg[i] <= d_reg[i-1];
                end
            end
        end
    end

    assign quo = q_reg[NUM_W-1];
    assign rem = r_reg[NUM_W-1];
endmodule

// ===== hdl/fixed_point_mul_div_mod.sv =====
// Top level of the pipelined Q fixed-point multiply/divide/modulo unit
//
//  channel | dir | tdata fields (low bit up)                 | tuser
//  s_axis  | in  | mode[1:0], operand_a[33:2], operand_b[65:34]| -
//  m_axis  | out | result_value[31:0]                         | saturated
//
// The request lands in the decode stage on the accepting edge, then passes FRAC_BITS+32
// divider stages (one quotient bit each), then the sign fix-up feeds the output register.
// One request is accepted every cycle while the pipe advances; the whole pipe advances when the output
// register is empty or being taken, and holds otherwise, so nothing is lost.
// Reset clears only the valid bits.
`timescale 1ns / 1ps
`include "fixed_point_mul_div_mod_assert.svh"
module fixed_point_mul_div_mod #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // mode, operand_a, operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // result_value
    output logic        m_axis_tuser   // saturated
);
    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int LAT = NUM_W + 2;

    logic ce;
    logic [LAT-1:0] vld_reg;
    fpmd_pkg::ctl_t ctl_d;
    fpmd_pkg::ctl_t ctl_reg [LAT-1];
    logic [NUM_W-1:0] num_d, num_reg, quo;
    logic [31:0] den_d, den_reg, rem, prod;
    logic signed [31:0] a, b, wa, wb, ub_m1;
    logic [31:0] res_next, res_reg;
    logic sat_reg;
    logic [31:0] qs, rs, radj;

    assign ce = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;
    assign a = s_axis_tdata[33:2];
    assign b = s_axis_tdata[65:34];
    assign wa = a[31] ? -a : a;
    assign wb = b[31] ? -b : b;
    assign ub_m1 = b - 32'sd1;

    always_comb begin
        ctl_d.mode = fpmd_pkg::mode_t'(s_axis_tdata[1:0]);
        ctl_d.sat = ((wa >>> fpmd_pkg::GUARD_SHIFT) >= wb) || (b == '0);
        ctl_d.sat_neg = a[31] ^ b[31];
        ctl_d.mask_mod = (b & ub_m1) == '0;
        ctl_d.mask_val = a & ub_m1;
        ctl_d.neg_q = a[31] ^ b[31];
        ctl_d.neg_r = a[31];
        ctl_d.b_val = b;
        num_d = {wa, {FRAC_BITS{1'b0}}};
        den_d = wb;
        if (ctl_d.mode == fpmd_pkg::MODE_MOD) begin
            num_d = NUM_W'(unsigned'(wa));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctl_reg[0] <= ctl_d;
            num_reg <= num_d;
            den_reg <= den_d;
            for (int i = 1; i < LAT - 1; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            res_reg <= res_next;
            sat_reg <= ctl_reg[LAT-2].mode == fpmd_pkg::MODE_DIV && ctl_reg[LAT-2].sat;
        end
    end

    fpmd_mul #(.FRAC_BITS(FRAC_BITS), .LAT(LAT - 1)) u_mul (
        .aclk(aclk), .ce(ce), .a(a), .b(b), .prod(prod)
    );

    fpmd_div #(.NUM_W(NUM_W)) u_div (
        .aclk(aclk), .ce(ce), .num(num_reg), .den(den_reg), .quo(quo), .rem(rem)
    );

    // Sign fix-up after the unsigned divide
    always_comb begin
        fpmd_pkg::ctl_t c;
        c = ctl_reg[LAT-2];
        qs = c.neg_q ? -quo[31:0] : quo[31:0];
        rs = c.neg_r ? -rem : rem;
        radj = rs[31] ? rs + c.b_val : rs;
        case (c.mode)
            fpmd_pkg::MODE_MUL: res_next = prod;
            fpmd_pkg::MODE_DIV: res_next = c.sat ? (c.sat_neg ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                                 : qs;
            fpmd_pkg::MODE_MOD: res_next = c.mask_mod ? c.mask_val : radj;
            default: res_next = '0;
        endcase
    end

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata = res_reg;
    assign m_axis_tuser = sat_reg;

    `FPMD_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `FPMD_ASSERT_IMPL(a_rdy, aclk, aresetn, !m_axis_tvalid, s_axis_tready)
    `FPMD_ASSERT_NEXT(a_flow, aclk, aresetn, ce && !vld_reg[LAT-2], !m_axis_tvalid)
endmodule

// ===== dv/tb_fixed_point_mul_div_mod.sv =====
// Testbench for the fixed-point multiply/divide/modulo unit: random and corner requests, scoreboard check
`timescale 1ns / 1ps
module tb_fixed_point_mul_div_mod;

    localparam int FRAC = 16;
    localparam int LATENCY = FRAC + 33;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct {
        logic [31:0] value;
        logic        sat;
    } fx_result_t;

    // Compute one result of the unit from mode and operands
    function automatic fx_result_t fx_compute(fpmd_pkg::mode_t mode, logic signed [31:0] a,
                                              logic signed [31:0] b);
        fx_result_t r;
        logic signed [63:0] prod;
        logic signed [31:0] abs_a;
        logic signed [31:0] abs_b;
        logic signed [63:0] num;
        logic signed [63:0] quo;
        logic signed [63:0] rem;
        logic [31:0] mask;
        r.value = '0;
        r.sat = 1'b0;
        case (mode)
            fpmd_pkg::MODE_MUL: begin
                prod = 64'(a) * 64'(b);
                prod = prod >>> FRAC;
                r.value = prod[31:0];
            end
            fpmd_pkg::MODE_DIV: begin
                abs_a = a[31] ? -a : a;
                abs_b = b[31] ? -b : b;
                if ((abs_a >>> 14) >= abs_b || b == 0) begin
                    r.sat = 1'b1;
                    r.value = (a[31] != b[31]) ? Q_MIN : Q_MAX;
                end else begin
                    num = 64'(a) <<< FRAC;
                    quo = num / 64'(b);
                    r.value = quo[31:0];
                end
            end
            fpmd_pkg::MODE_MOD: begin
                mask = b - 32'd1;
                if ((b & mask) == 0) begin
                    r.value = a & mask;
                end else begin
                    rem = 64'(a) % 64'(b);
                    r.value = rem[31:0];
                    if (rem < 0) r.value = rem[31:0] + b;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    class fx_scoreboard;
        fx_result_t pending[$];
        int errors = 0;

        function void note_request(fpmd_pkg::mode_t mode, logic [31:0] a, logic [31:0] b);
            pending.push_back(fx_compute(mode, a, b));
        endfunction

        function void check_result(logic [31:0] value, logic sat);
            fx_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%h sat=%b", $time, value, sat);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (value !== e.value) begin
                $display("%0t: result_value expected %h actual %h", $time, e.value, value);
                errors++;
            end
            if (sat !== e.sat) begin
                $display("%0t: saturated expected %b actual %b", $time, e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;  // mode[1:0], operand_a[33:2], operand_b[65:34]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // result_value
    logic        m_axis_tuser;       // saturated

    fx_scoreboard sb = new();
    bit quiet_tail = 1'b0;
    bit hold_off = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    fixed_point_mul_div_mod #(.FRAC_BITS(FRAC)) i_dut (.*);

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Receiver: random stalls, one long hold-off while the sender keeps pushing
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (3 * LATENCY) @(posedge aclk);
                hold_off = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 12);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_request(fpmd_pkg::mode_t mode, logic [31:0] a, logic [31:0] b);
        int n;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, b, a, mode};
        @(posedge aclk iff s_axis_tready);
        sb.note_request(mode, a, b);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4: return 32'd1 << $urandom_range(0, 31);
            5: return $urandom_range(0, 1) ? $urandom_range(0, 32'h3_FFFF)
                                           : -$urandom_range(0, 32'h3_FFFF);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        fpmd_pkg::mode_t m;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Corner cases
        send_request(fpmd_pkg::MODE_MUL, Q_MAX, Q_MAX);
        send_request(fpmd_pkg::MODE_MUL, Q_MIN, Q_MIN);
        send_request(fpmd_pkg::MODE_MUL, Q_MIN, 32'h0001_0000);
        send_request(fpmd_pkg::MODE_MUL, 32'hFFFF_FFFF, 32'd1);
        send_request(fpmd_pkg::MODE_DIV, 32'h0003_0000, 32'h0002_0000);
        send_request(fpmd_pkg::MODE_DIV, 32'd5, 32'd0);
        send_request(fpmd_pkg::MODE_DIV, Q_MIN, 32'd0);
        send_request(fpmd_pkg::MODE_DIV, Q_MIN, 32'hFFFF_FFFF);
        send_request(fpmd_pkg::MODE_DIV, Q_MAX, Q_MIN);
        send_request(fpmd_pkg::MODE_DIV, -32'sh0001_0000, 32'h0003_0000);
        send_request(fpmd_pkg::MODE_DIV, 32'h0004_0000, 32'd1);
        send_request(fpmd_pkg::MODE_MOD, 32'd12345, Q_MIN);
        send_request(fpmd_pkg::MODE_MOD, -32'sd7, 32'd0);
        send_request(fpmd_pkg::MODE_MOD, Q_MIN, 32'hFFFF_FFFF);
        send_request(fpmd_pkg::MODE_MOD, -32'sd7, 32'd3);
        send_request(fpmd_pkg::MODE_MOD, Q_MIN, Q_MAX);
        send_request(fpmd_pkg::MODE_MOD, 32'd100, 32'd16);
        send_request(fpmd_pkg::MODE_MOD, Q_MAX, -32'sd3);
        send_request(fpmd_pkg::MODE_NONE, Q_MAX, Q_MIN);
        // Fill the pipe against a stalled receiver
        hold_off = 1'b1;
        for (int i = 0; i < 1900; i++) begin
            if (i == 1700) quiet_tail = 1'b1;
            m = fpmd_pkg::mode_t'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
            send_request(m, pick_operand(), pick_operand());
        end
        s_axis_tvalid <= 1'b0;
        fork
            begin
                while (sb.pending.size() != 0) @(posedge aclk);
                repeat (LATENCY + 10) @(posedge aclk);
            end
            begin
                repeat (200000) @(posedge aclk);
                $display("%0t: results still pending at end", $time);
                sb.errors++;
            end
        join_any
        if (sb.errors == 0) $display("** fixed_point_mul_div_mod: PASSED **");
        else $display("** fixed_point_mul_div_mod: FAILED **");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("** fixed_point_mul_div_mod: FAILED **");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/fpmd_pkg.sv
hdl/fpmd_mul.sv
hdl/fpmd_div.sv
hdl/fixed_point_mul_div_mod.sv
dv/tb_fixed_point_mul_div_mod.sv
